// File: rtl/core/ipmt_pkg.sv
package ipmt_pkg;

   // Default sizes of the table and the time base.
   localparam int SLOTS_DEFAULT     = 64;
   localparam int TIME_BITS_DEFAULT = 48;

   // Reset value of the registration limit.
   localparam logic [6:0] MAX_MONITORS_RESET = 7'd64;

   // Request kinds.
   localparam logic [1:0] KIND_REGISTER = 2'd0;
   localparam logic [1:0] KIND_START    = 2'd1;
   localparam logic [1:0] KIND_STOP     = 2'd2;
   localparam logic [1:0] KIND_QUERY    = 2'd3;

   // Operand widths of the serial divider that forms the average.
   localparam int DIV_NUM_BITS = 64;
   localparam int DIV_DEN_BITS = 32;

endpackage

// File: rtl/core/ipmt_div.sv
module ipmt_div
   import ipmt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIV_NUM_BITS-1:0] dividend,
   input  logic [DIV_DEN_BITS-1:0] divisor,
   output logic                    done,
   output logic [DIV_NUM_BITS-1:0] quotient
);

   localparam int CW = $clog2(DIV_NUM_BITS);

   logic                    busy_ff;
   logic                    done_ff;
   logic [CW-1:0]           cnt_ff;
   logic [DIV_NUM_BITS-1:0] quo_ff;
   logic [DIV_DEN_BITS-1:0] rem_ff;
   logic [DIV_DEN_BITS-1:0] den_ff;
   logic [DIV_DEN_BITS:0]   trial;
   logic                    fits;

   // One quotient bit per cycle: shift the next dividend bit into the remainder.
   assign trial = {rem_ff, quo_ff[DIV_NUM_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (&cnt_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath of the restoring divider.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_NUM_BITS-2:0], fits};
         if (fits) begin
            rem_ff <= DIV_DEN_BITS'(trial - {1'b0, den_ff});
         end else begin
            rem_ff <= trial[DIV_DEN_BITS-1:0];
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/interval_profiling_monitor_table_core.sv
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tuser kind, tdata handle .. traced_flag
// rsp      out        rsp_tvalid/tready     tuser status, tdata assigned_handle .. minimum_out
// csr      in         csr_wr_en             csr_wr_data max_monitors
//
// A register, start or query request, or a stop request that fails its handle check,
// passes through the read, calc and output phases before its result is valid and the input
// takes the next request. A valid stop request also waits in the divide phase for the
// 64-step serial divider that forms the average.
// One request is in work at a time; the next is accepted once the result sits in the
// output register, even while that result waits for rsp_tready.
// Synchronous reset clears the slot count and restores the limit to 64; slot records are
// zeroed when a slot is registered, so no clearing pass runs after reset.
module interval_profiling_monitor_table_core
   import ipmt_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // handle[5:0], timestamp[53:6], page[57:54], minimum_flag[58], budget[90:59],
   // traced_flag[91], zero fill[95:92]
   input  logic [95:0]  req_tdata,
   // kind[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // assigned_handle[5:0], last_elapsed[53:6], average_elapsed[101:54],
   // max_elapsed[149:102], call_count[181:150], budget_out[213:182],
   // over_budget[214], page_out[218:215], traced_out[219], minimum_out[220],
   // zero fill[223:221]
   output logic [223:0] rsp_tdata,
   // status[0]
   output logic [0:0]   rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int UW = $clog2(SLOTS + 1);
   localparam int TW = TIME_BITS;
   localparam logic [63:0] TMASK = {64{1'b1}} >> (64 - TIME_BITS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_CALC = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   typedef struct packed {
      logic [TW-1:0] start;
      logic [TW-1:0] last;
      logic [63:0]   sum;
      logic [TW-1:0] avg;
      logic [TW-1:0] maxv;
      logic [31:0]   cnt;
      logic [31:0]   budget;
      logic [5:0]    attrs;
   } rec_type;

   rec_type rec_mem [SLOTS];

   logic [2:0]    state_ff, state_in;
   logic [1:0]    kind_ff;
   logic [TW-1:0] ts_ff;
   logic [3:0]    page_ff;
   logic          min_ff;
   logic          traced_ff;
   logic [31:0]   budget_ff;
   logic [6:0]    max_mon_ff;
   logic [UW-1:0] used_ff;
   logic          err_ff;
   logic [SW-1:0] slot_ff;
   rec_type       rd_ff;
   rec_type       rec_ff, rec_in;
   logic          rsp_valid_ff;
   logic [223:0]  rsp_data_ff;
   logic          rsp_status_ff;

   logic          accept;
   logic [10:0]   limit;
   logic [1:0]    req_kind;
   logic [5:0]    req_handle;
   logic [TW-1:0] elapsed;
   logic [64:0]   sum_wide;
   logic [63:0]   sum_new;
   logic [31:0]   cnt_new;
   logic          div_start;
   logic          div_done;
   logic [63:0]   quotient;
   logic [TW-1:0] avg_new;
   logic          out_free;
   logic          over;

   assign req_kind   = req_tuser;
   assign req_handle = req_tdata[5:0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign limit      = (11'(max_mon_ff) < 11'(SLOTS)) ? 11'(max_mon_ff) : 11'(SLOTS);

   // Stop arithmetic: wrapping elapsed time, saturating sum and count.
   assign elapsed  = ts_ff - rd_ff.start;
   assign sum_wide = {1'b0, rd_ff.sum} + 65'(elapsed);
   assign sum_new  = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
   assign cnt_new  = (&rd_ff.cnt) ? rd_ff.cnt : rd_ff.cnt + 32'd1;
   assign div_start = (state_ff == S_CALC) && !err_ff && (kind_ff == KIND_STOP);
   assign avg_new  = (quotient > TMASK) ? TW'(TMASK) : TW'(quotient);

   ipmt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (cnt_new),
      .done     (div_done),
      .quotient (quotient)
   );

   // Sequencer over the phases of one request.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_READ;
         S_READ: state_in = S_CALC;
         S_CALC: begin
            if (div_start) state_in = S_DIV;
            else state_in = S_OUT;
         end
         S_DIV:  if (div_done) state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_mon_ff   <= MAX_MONITORS_RESET;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            max_mon_ff <= csr_wr_data;
         end
         if (state_ff == S_CALC && !err_ff && kind_ff == KIND_REGISTER) begin
            used_ff <= used_ff + 1'b1;
         end
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture, slot selection and error check.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         ts_ff     <= TW'(req_tdata[53:6]);
         page_ff   <= req_tdata[57:54];
         min_ff    <= req_tdata[58];
         budget_ff <= req_tdata[90:59];
         traced_ff <= req_tdata[91];
         if (req_kind == KIND_REGISTER) begin
            slot_ff <= SW'(used_ff);
            err_ff  <= 11'(used_ff) >= limit;
         end else begin
            slot_ff <= SW'(req_handle);
            err_ff  <= 11'(req_handle) >= 11'(used_ff);
         end
      end
   end

   // Slot record memory: registered read, write of the updated record.
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_ff <= rec_mem[slot_ff];
      end
      if (state_ff == S_OUT && !err_ff && kind_ff != KIND_QUERY) begin
         rec_mem[slot_ff] <= rec_ff;
      end
   end

   // Working record update.
   always_comb begin
      rec_in = rec_ff;
      if (state_ff == S_CALC) begin
         rec_in = rd_ff;
         case (kind_ff)
            KIND_REGISTER: begin
               rec_in        = '0;
               rec_in.budget = budget_ff;
               rec_in.attrs  = {traced_ff, min_ff, page_ff};
            end
            KIND_START: rec_in.start = ts_ff;
            KIND_STOP: begin
               rec_in.last = elapsed;
               rec_in.sum  = sum_new;
               rec_in.cnt  = cnt_new;
               if (elapsed > rd_ff.maxv) rec_in.maxv = elapsed;
            end
            default: ;
         endcase
      end else if (state_ff == S_DIV && div_done) begin
         rec_in.avg = avg_new;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   // Result register.
   assign over = (rec_ff.budget != 32'd0) && (64'(rec_ff.last) > 64'(rec_ff.budget));

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_status_ff <= err_ff;
         if (err_ff) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff <= {3'b000, rec_ff.attrs[4], rec_ff.attrs[5], rec_ff.attrs[3:0],
                            over, rec_ff.budget, rec_ff.cnt, 48'(rec_ff.maxv),
                            48'(rec_ff.avg), 48'(rec_ff.last), 6'(slot_ff)};
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_status_ff;

`ifndef SYNTH
   // The slot count never passes the table size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= SLOTS)
      else $error("slot count beyond table size");

   // The slot count moves only by one, and only after a register request.
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |->
         (used_ff == $past(used_ff) + 1'b1) && ($past(kind_ff) == KIND_REGISTER))
      else $error("slot count changed unexpectedly");

   // A new result appears only from the output phase.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_OUT))
      else $error("result without output phase");

   // The divider finishes only while the sequencer waits for it.
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider done outside wait phase");
`endif

endmodule
